/* rtl/sfrp_pkg.sv */
package sfrp_pkg;

  // Reply framing.
  localparam int unsigned FRAME_BYTES = 12;
  localparam int unsigned DATA_W = 48;
  localparam logic [3:0] FRAME_LEN = 4'd12;
  localparam logic [3:0] LAST_INDEX = 4'd11;
  localparam logic [3:0] IDX_HEADER1 = 4'd0;
  localparam logic [3:0] IDX_HEADER2 = 4'd1;
  localparam logic [3:0] IDX_ID = 4'd2;
  localparam logic [3:0] IDX_LENGTH = 4'd3;
  localparam logic [3:0] IDX_STATE = 4'd4;
  localparam logic [3:0] IDX_DATA_FIRST = 4'd5;
  localparam logic [3:0] IDX_DATA_LAST = 4'd10;

  // Expected byte values.
  localparam logic [7:0] HEADER_BYTE = 8'hFF;
  localparam logic [7:0] LENGTH_BYTE = 8'h08;
  localparam logic [7:0] STATE_BYTE = 8'h00;

  // Sign positions of the decoded fields.
  localparam int unsigned SPEED_SIGN_BIT = 15;
  localparam int unsigned LOAD_SIGN_BIT = 10;

  // Depth of the queue between the parser and the decoder.
  localparam int unsigned JOB_QUEUE_DEPTH = 4;

  // Input item actions.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_WINDOW_END = 1'b1;

  typedef logic [3:0] count_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_CHECKSUM = 3'd1,
    ST_SYNTAX = 3'd2,
    ST_TRUNC = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  // One classified reply handed from the parser to the decoder.
  typedef struct packed {
    status_t status;
    logic [DATA_W-1:0] data;
    logic signed [15:0] offset;
  } job_t;

  // Fill flags of a queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_flags_t;

endpackage

/* rtl/sfrp_front.sv */
module sfrp_front
  import sfrp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               action,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         expected_id,
  input  logic signed [15:0] cal_offset,
  output logic               job_valid,
  output job_t               job
);

  count_t            byte_count, byte_count_next;
  logic [7:0]        sum_accum, sum_accum_next;
  logic              syntax_ok, syntax_ok_next;
  logic [DATA_W-1:0] data_bytes, data_bytes_next;
  logic              take_byte;

  // Per-byte framing checks and classification of each transaction.
  always_comb begin
    byte_count_next = byte_count;
    sum_accum_next = sum_accum;
    syntax_ok_next = syntax_ok;
    data_bytes_next = data_bytes;
    job_valid = 1'b0;
    job.status = ST_OK;
    job.data = data_bytes;
    job.offset = cal_offset;
    take_byte = accept && (action == ACT_BYTE) && (byte_count < FRAME_LEN);

    if (accept && (action == ACT_WINDOW_END)) begin
      // The window closes: report a short window and start over.
      byte_count_next = '0;
      sum_accum_next = '0;
      syntax_ok_next = 1'b1;
      if (byte_count == '0) begin
        job_valid = 1'b1;
        job.status = ST_TIMEOUT;
      end else if (byte_count < FRAME_LEN) begin
        job_valid = 1'b1;
        job.status = ST_TRUNC;
      end
    end else if (take_byte) begin
      byte_count_next = byte_count + 4'd1;
      if (((byte_count == IDX_HEADER1) || (byte_count == IDX_HEADER2))
          && (rx_byte != HEADER_BYTE)) begin
        syntax_ok_next = 1'b0;
      end
      if ((byte_count == IDX_ID) && (rx_byte != expected_id)) begin
        syntax_ok_next = 1'b0;
      end
      if ((byte_count == IDX_LENGTH) && (rx_byte != LENGTH_BYTE)) begin
        syntax_ok_next = 1'b0;
      end
      if ((byte_count == IDX_STATE) && (rx_byte != STATE_BYTE)) begin
        syntax_ok_next = 1'b0;
      end
      if ((byte_count >= IDX_ID) && (byte_count <= IDX_DATA_LAST)) begin
        sum_accum_next = sum_accum + rx_byte;
      end
      if ((byte_count >= IDX_DATA_FIRST) && (byte_count <= IDX_DATA_LAST)) begin
        data_bytes_next = {data_bytes[DATA_W-9:0], rx_byte};
      end
      // The checksum byte closes the reply; syntax errors win over checksum errors.
      if (byte_count == LAST_INDEX) begin
        job_valid = 1'b1;
        if (!syntax_ok) begin
          job.status = ST_SYNTAX;
        end else if (rx_byte != ~sum_accum) begin
          job.status = ST_CHECKSUM;
        end else begin
          job.status = ST_OK;
        end
      end
    end
  end

  // Parser state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      sum_accum <= '0;
      syntax_ok <= 1'b1;
    end else begin
      byte_count <= byte_count_next;
      sum_accum <= sum_accum_next;
      syntax_ok <= syntax_ok_next;
    end
  end

  // Captured data bytes need no reset.
  always_ff @(posedge clk) begin
    data_bytes <= data_bytes_next;
  end

endmodule

/* rtl/sfrp_queue.sv */
module sfrp_queue
  import sfrp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_en,
  input  job_t     wr_data,
  input  logic     rd_en,
  output job_t     rd_data,
  output q_flags_t flags
);

  localparam int unsigned PTR_W = (JOB_QUEUE_DEPTH > 1) ? $clog2(JOB_QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(JOB_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(JOB_QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(JOB_QUEUE_DEPTH);

  job_t             entries [JOB_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign flags.full = (count == CNT_FULL);
  assign flags.empty = (count == '0);
  assign do_wr = wr_en && !flags.full;
  assign do_rd = rd_en && !flags.empty;
  assign rd_data = entries[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

/* rtl/sfrp_back.sv */
module sfrp_back
  import sfrp_pkg::*;
#(
  parameter int unsigned POSITION_MAX = 1023
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_avail,
  input  job_t               job,
  output logic               job_take,
  input  logic               pop,
  output logic               empty,
  output logic [2:0]         status,
  output logic [9:0]         position,
  output logic signed [15:0] speed,
  output logic signed [15:0] load
);

  localparam logic signed [16:0] POS_LIMIT = 17'(POSITION_MAX);

  logic              out_valid;
  logic [15:0]       raw_pos, raw_spd, raw_ld;
  logic signed [16:0] pos_sum, pos_clamped;
  logic [15:0]       spd_dec, ld_dec;
  logic              is_ok;

  assign raw_pos = job.data[47:32];
  assign raw_spd = job.data[31:16];
  assign raw_ld = job.data[15:0];
  assign is_ok = (job.status == ST_OK);

  // Field decode: clamped calibrated position, sign-magnitude speed, load.
  always_comb begin
    pos_sum = {raw_pos[15], raw_pos} + {job.offset[15], job.offset};
    if (pos_sum < 0) begin
      pos_clamped = '0;
    end else if (pos_sum > POS_LIMIT) begin
      pos_clamped = POS_LIMIT;
    end else begin
      pos_clamped = pos_sum;
    end
    if (raw_spd[SPEED_SIGN_BIT]) begin
      spd_dec = 16'd0 - {1'b0, raw_spd[14:0]};
    end else begin
      spd_dec = raw_spd;
    end
    if (raw_ld[LOAD_SIGN_BIT]) begin
      ld_dec = 16'd0 - (raw_ld & ~(16'd1 << LOAD_SIGN_BIT));
    end else begin
      ld_dec = raw_ld;
    end
  end

  // The output register takes a new job whenever it is free or being drained.
  assign job_take = job_avail && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload; decoded fields are zero unless the reply was good.
  always_ff @(posedge clk) begin
    if (job_take) begin
      status <= job.status;
      position <= is_ok ? pos_clamped[9:0] : '0;
      speed <= is_ok ? $signed(spd_dec) : '0;
      load <= is_ok ? $signed(ld_dec) : '0;
    end
  end

endmodule

/* rtl/servo_feedback_reply_parser_unit.sv */
// A completed reply's job passes through the job queue and then into the output register;
// while the result side stalls it waits in the queue.
// Throughput: one input transaction per cycle while the job queue is not full, set by the
// combinational byte step of the parser and the decode into the output register; a
// four-entry job queue between them absorbs result-side stalls. Synchronous reset clears
// the parser and empties both the job queue and the output register.
module servo_feedback_reply_parser_unit
  import sfrp_pkg::*;
#(
  parameter int unsigned POSITION_MAX = 1023
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               action,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         expected_id,
  input  logic signed [15:0] cal_offset,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         status,
  output logic [9:0]         position,
  output logic signed [15:0] speed,
  output logic signed [15:0] load
);

  logic     accept;
  logic     job_valid;
  job_t     job_in;
  job_t     job_out;
  q_flags_t mid_flags;
  logic     mid_pop;

  assign full = mid_flags.full;
  assign accept = push && !mid_flags.full;

  // Front: byte framing, checks and classification.
  sfrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (action),
    .rx_byte    (rx_byte),
    .expected_id(expected_id),
    .cal_offset (cal_offset),
    .job_valid  (job_valid),
    .job        (job_in)
  );

  // Job queue between the parser and the decoder.
  sfrp_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (job_valid),
    .wr_data(job_in),
    .rd_en  (mid_pop),
    .rd_data(job_out),
    .flags  (mid_flags)
  );

  // Back: field decode and result register.
  sfrp_back #(
    .POSITION_MAX(POSITION_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .job_avail(!mid_flags.empty),
    .job      (job_out),
    .job_take (mid_pop),
    .pop      (pop),
    .empty    (empty),
    .status   (status),
    .position (position),
    .speed    (speed),
    .load     (load)
  );

  // A failed or short reply never carries decoded fields.
  assert property (@(posedge clk) disable iff (rst)
    (!empty && (status != ST_OK)) |-> ((position == '0) && (speed == '0) && (load == '0)))
    else $error("non-ok result carries nonzero fields");

  // The decoder only takes jobs that are in the queue.
  assert property (@(posedge clk) disable iff (rst) mid_pop |-> !mid_flags.empty)
    else $error("job taken from an empty queue");

  // Reset leaves both sides empty.
  assert property (@(posedge clk) (!rst && $past(rst)) |-> (empty && !full))
    else $error("queues not empty after reset");

endmodule
